@@ rtl/core/residue_set_pattern_parser_assert.svh @@
// assertion macros for the residue set pattern parser
// included by rtl/core/residue_set_pattern_parser.sv, no other dependencies
`ifndef RESIDUE_SET_PATTERN_PARSER_ASSERT_SVH
`define RESIDUE_SET_PATTERN_PARSER_ASSERT_SVH

// clocked assertion, off while reset is high
`define RSPAT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RSPAT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/rspat_pkg.sv @@
// types, widths and residue lookup for the residue set pattern parser
// no dependencies; imported by rtl/core/residue_set_pattern_parser.sv
package rspat_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned MaskWidth  = 21;
   localparam int unsigned IndexWidth = 8;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned CodeWidth  = 5;
   localparam int unsigned AlphabetSize = 20;

   // bits 0 up to the alphabet size, all set
   localparam logic [MaskWidth-1:0] UniversalMask =
      MaskWidth'((64'd1 << (AlphabetSize + 1)) - 64'd1);

   localparam logic [CountWidth-1:0] MaxSetsReset = 9'd256;

   typedef struct packed {
      logic [CharWidth-1:0] ch;
      logic                 last;
   } req_item_type;

   typedef struct packed {
      logic                  set_valid;
      logic [MaskWidth-1:0]  set_mask;
      logic [IndexWidth-1:0] set_index;
      logic                  syntax_error;
      logic [CountWidth-1:0] set_total;
   } rsp_item_type;

   // residue code 1..20 of a letter (either case), 0 when not a residue
   function automatic logic [CodeWidth-1:0] residue_code(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] u;
      logic [CodeWidth-1:0] code;
      u = c;
      if (c >= "a" && c <= "z") begin
         u = c - 8'd32;
      end
      case (u)
         "C":     code = 5'd1;
         "G":     code = 5'd2;
         "A":     code = 5'd3;
         "S":     code = 5'd4;
         "T":     code = 5'd5;
         "N":     code = 5'd6;
         "D":     code = 5'd7;
         "E":     code = 5'd8;
         "Q":     code = 5'd9;
         "K":     code = 5'd10;
         "R":     code = 5'd11;
         "H":     code = 5'd12;
         "W":     code = 5'd13;
         "Y":     code = 5'd14;
         "F":     code = 5'd15;
         "V":     code = 5'd16;
         "I":     code = 5'd17;
         "L":     code = 5'd18;
         "M":     code = 5'd19;
         "P":     code = 5'd20;
         default: code = 5'd0;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/core/residue_set_pattern_parser.sv @@
// residue set pattern parser top level: input register, parse logic, result register
// depends on rtl/core/rspat_pkg.sv and rtl/core/residue_set_pattern_parser_assert.svh
//
// Usage: pattern characters enter on req_valid/req_ready with req_item (ch, last).
// Every character gives exactly one result item on rsp_valid/rsp_ready (rsp_item):
// set_valid with the finished residue set, its index, the sticky syntax_error
// flag and the number of sets so far. An item marked last is reported, then
// the parser returns to its start state for the next pattern.
// An accepted item is held in the input register and then written to the
// result register, where rsp_valid rises with it. Throughput: one item per
// cycle while rsp_ready is high; the parse state is computed from the
// input register, so items follow back to back.
// When rsp_ready is low the result register holds; one more item waits in the
// input register, then req_ready drops until the result is taken.
// Reset (synchronous, active high) empties both registers, clears the parse
// state and sets the limit register to 256. csr_we writes the limit from
// csr_wdata; write it only while no item is in flight.
`include "residue_set_pattern_parser_assert.svh"

module residue_set_pattern_parser #(
   parameter int unsigned MAX_PATTERN = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rspat_pkg::req_item_type    req_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rspat_pkg::rsp_item_type    rsp_item,
   input  logic                       csr_we,
   input  logic [rspat_pkg::CountWidth-1:0] csr_wdata
);
   import rspat_pkg::*;

   // parse states
   localparam logic [2:0] StBegin  = 3'd0;
   localparam logic [2:0] StOpen   = 3'd1;
   localparam logic [2:0] StInside = 3'd2;
   localparam logic [2:0] StSingle = 3'd3;
   localparam logic [2:0] StClosed = 3'd4;
   localparam logic [2:0] StDot    = 3'd5;

   localparam logic [12:0] MaxPattern = 13'(MAX_PATTERN);

   logic                  in_valid_ff;
   req_item_type          in_item_ff;
   logic                  rsp_valid_ff;
   rsp_item_type          rsp_item_ff;
   logic [2:0]            state_ff, state_in;
   logic [MaskWidth-1:0]  partial_ff, partial_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  err_ff, err_in;
   logic [CountWidth-1:0] max_sets_ff;
   logic [CountWidth-1:0] limit;
   logic                  advance;
   rsp_item_type          result;

   // handshake: a new item enters whenever the input register empties or moves on
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // effective set limit
   assign limit = (13'(max_sets_ff) < MaxPattern) ? max_sets_ff : MaxPattern[CountWidth-1:0];

   // parse one character
   always_comb begin
      logic [CodeWidth-1:0] code;
      logic [MaskWidth-1:0] bit_mask;
      logic [MaskWidth-1:0] emask;
      logic [2:0]           next;
      logic                 bad;
      logic                 emit;
      code     = residue_code(in_item_ff.ch);
      bit_mask = MaskWidth'(1) << code;
      emask    = '0;
      next     = state_ff;
      bad      = 1'b0;
      emit     = 1'b0;
      partial_in = partial_ff;
      state_in   = state_ff;
      count_in   = count_ff;
      err_in     = err_ff;
      result.set_valid = 1'b0;
      result.set_mask  = '0;
      result.set_index = '0;

      if (!err_ff) begin
         if (in_item_ff.ch == "{") begin
            if (state_ff == StBegin || state_ff == StClosed ||
                state_ff == StSingle || state_ff == StDot) begin
               partial_in = '0;
               next = StOpen;
            end else begin
               bad = 1'b1;
            end
         end else if (in_item_ff.ch == "}") begin
            if (state_ff == StInside) begin
               emit  = 1'b1;
               emask = partial_ff;
               next  = StClosed;
            end else begin
               bad = 1'b1;
            end
         end else if (in_item_ff.ch == ".") begin
            if (state_ff == StClosed || state_ff == StSingle || state_ff == StDot) begin
               emit  = 1'b1;
               emask = UniversalMask;
               next  = StDot;
            end else begin
               bad = 1'b1;
            end
         end else if (code == '0) begin
            bad = 1'b1;
         end else if (state_ff == StOpen) begin
            partial_in = bit_mask;
            next = StInside;
         end else if (state_ff == StInside) begin
            partial_in = partial_ff | bit_mask;
         end else begin
            emit  = 1'b1;
            emask = bit_mask;
            next  = StSingle;
         end

         // too many sets
         if (!bad && emit && count_ff >= limit) begin
            bad = 1'b1;
         end

         if (bad) begin
            err_in     = 1'b1;
            partial_in = partial_ff;
         end else begin
            state_in = next;
            if (emit) begin
               result.set_valid = 1'b1;
               result.set_mask  = emask;
               result.set_index = count_ff[IndexWidth-1:0];
               count_in = count_ff + 9'd1;
            end
         end
      end

      result.syntax_error = err_in;
      result.set_total    = count_in;

      // end of pattern: back to the start state after reporting
      if (in_item_ff.last) begin
         state_in   = StBegin;
         partial_in = '0;
         count_in   = '0;
         err_in     = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= StBegin;
         partial_ff   <= '0;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         max_sets_ff  <= MaxSetsReset;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            partial_ff   <= partial_in;
            count_ff     <= count_in;
            err_ff       <= err_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            max_sets_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   // checks on the result register
   `RSPAT_ASSERT(a_index_tracks_count, clock, reset,
      rsp_valid_ff && rsp_item_ff.set_valid |->
         rsp_item_ff.set_index == 8'(rsp_item_ff.set_total - 9'd1),
      "emitted set index does not match the set count")
   `RSPAT_ASSERT(a_set_without_error, clock, reset,
      rsp_valid_ff && rsp_item_ff.set_valid |-> !rsp_item_ff.syntax_error,
      "set emitted while the error flag is up")
   `RSPAT_ASSERT(a_idle_fields_zero, clock, reset,
      rsp_valid_ff && !rsp_item_ff.set_valid |->
         rsp_item_ff.set_mask == '0 && rsp_item_ff.set_index == '0,
      "mask or index nonzero without a set")
   `RSPAT_ASSERT(a_set_not_empty, clock, reset,
      rsp_valid_ff && rsp_item_ff.set_valid |-> rsp_item_ff.set_mask != '0,
      "emitted residue set is empty")

endmodule
